### hw/rtl/assert_macros.svh
// Assertion macros for the RTL files (used by random_nqueens_placer.sv).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted (active-low reset).
`define NQP_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define NQP_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/nqp_pkg.sv
// Constants and register map of the random N-queens placer.
`default_nettype none

package nqp_pkg;

  // Board geometry
  localparam int MAX_QUEENS   = 32;
  localparam int QW           = $clog2(MAX_QUEENS);       // row / column index bits
  localparam int CNT_W        = QW + 1;                   // counts up to MAX_QUEENS
  localparam int DIAG_N       = 2 * MAX_QUEENS - 1;       // diagonals per direction
  localparam int DIAG_W       = $clog2(DIAG_N);

  // Random word
  localparam int RANDOM_WIDTH = 16;
  localparam int RBIT_W       = $clog2(RANDOM_WIDTH);

  // Transaction field widths
  localparam int ROW_W        = 5;
  localparam int COLUMN_W     = 5;
  localparam int COUNT_W      = 6;

  // Configuration port
  localparam int SIZE_W       = 6;
  localparam int DATA_W       = 32;
  localparam int ADDR_W       = 3;
  localparam int REG_IDX_W    = ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_BOARD_SIZE = 1'b0;
  localparam logic [SIZE_W-1:0]    BOARD_SIZE_RST = 6'd8;

endpackage

`default_nettype wire

### hw/rtl/nqp_if.sv
// Valid/ready channel interfaces for the placer's input and result streams.
`default_nettype none

interface nqp_in_if;
  logic                            valid;
  logic                            ready;
  logic [nqp_pkg::RANDOM_WIDTH-1:0] random_value;

  modport source (output valid, output random_value, input ready);
  modport sink   (input valid, input random_value, output ready);
endinterface

interface nqp_out_if;
  logic                        valid;
  logic                        ready;
  logic [nqp_pkg::ROW_W-1:0]    row;
  logic [nqp_pkg::COLUMN_W-1:0] column;
  logic [nqp_pkg::COUNT_W-1:0]  candidate_count;
  logic                        status;
  logic                        last;

  modport source (output valid, output row, output column, output candidate_count,
                  output status, output last, input ready);
  modport sink   (input valid, input row, input column, input candidate_count,
                  input status, input last, output ready);
endinterface

`default_nettype wire

### hw/rtl/random_nqueens_placer.sv
// Random N-queens placer: one row per input transaction, iterative column scan.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+---------------------------------------------
//  in_i    | in  | valid / ready        | random_value
//  out_o   | out | valid / ready        | row, column, candidate_count, status, last
//  apb     | in  | psel/penable/pready  | paddr, pwdata, pwrite / prdata (board_size)
//
// Steps: one transaction scans the n columns (n = effective board size) to count
// free columns, then takes the restoring remainder of random_value by that count
// (one random bit per cycle), then walks to the ranked column, then the result.
// A dead end skips remainder and walk.
// in_i.ready is high only while idle; the result register holds until out_o.ready.
// Reset (rst_ni, async low) clears the board, sets board_size to 8, and idles.
`default_nettype none
`include "assert_macros.svh"

module random_nqueens_placer (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  nqp_in_if.sink                           in_i,
  nqp_out_if.source                        out_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [nqp_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [nqp_pkg::DATA_W-1:0]  pwdata,
  output logic      [nqp_pkg::DATA_W-1:0]  prdata,
  output logic                             pready
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_COUNT = 5'b00010,
    ST_MOD   = 5'b00100,
    ST_PICK  = 5'b01000,
    ST_OUT   = 5'b10000
  } state_e;

  // Control state
  state_e                              state_q, state_d;
  logic [nqp_pkg::SIZE_W-1:0]          board_size_q, board_size_d;
  logic [nqp_pkg::MAX_QUEENS-1:0]      colm_q, colm_d;
  logic [nqp_pkg::DIAG_N-1:0]          rise_q, rise_d;
  logic [nqp_pkg::DIAG_N-1:0]          fall_q, fall_d;
  logic [nqp_pkg::CNT_W-1:0]           next_row_q, next_row_d;

  // Working / result registers
  logic [nqp_pkg::RANDOM_WIDTH-1:0]    rnd_q, rnd_d;
  logic [nqp_pkg::QW-1:0]              row_q, row_d;
  logic [nqp_pkg::CNT_W-1:0]           col_q, col_d;
  logic [nqp_pkg::CNT_W-1:0]           count_q, count_d;
  logic [nqp_pkg::CNT_W-1:0]           rem_q, rem_d;
  logic [nqp_pkg::CNT_W-1:0]           seen_q, seen_d;
  logic [nqp_pkg::RBIT_W-1:0]          bit_q, bit_d;
  logic [nqp_pkg::QW-1:0]              chosen_q, chosen_d;
  logic                                status_q, status_d;
  logic                                last_q, last_d;

  // Shared column test
  logic [nqp_pkg::CNT_W-1:0]           n_eff;
  logic [nqp_pkg::DIAG_W-1:0]          rise_idx, fall_idx;
  logic                                col_safe;
  logic [nqp_pkg::CNT_W-1:0]           count_nx;
  logic [nqp_pkg::CNT_W:0]             rem_ext;
  logic [nqp_pkg::CNT_W-1:0]           row_nx;
  logic                                cfg_wr;
  logic [nqp_pkg::REG_IDX_W-1:0]       reg_idx;

  assign reg_idx = paddr[nqp_pkg::ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_comb begin
    prdata = '0;
    if (reg_idx == nqp_pkg::REG_BOARD_SIZE) begin
      prdata = nqp_pkg::DATA_W'(board_size_q);
    end
  end

  // Size 0 acts as 1, sizes above the maximum saturate.
  always_comb begin
    if (board_size_q == '0) begin
      n_eff = nqp_pkg::CNT_W'(1);
    end else if (nqp_pkg::CNT_W'(board_size_q) > nqp_pkg::CNT_W'(nqp_pkg::MAX_QUEENS)) begin
      n_eff = nqp_pkg::CNT_W'(nqp_pkg::MAX_QUEENS);
    end else begin
      n_eff = nqp_pkg::CNT_W'(board_size_q);
    end
  end

  // One column of the current row against all three masks
  assign rise_idx = nqp_pkg::DIAG_W'(row_q) + nqp_pkg::DIAG_W'(col_q[nqp_pkg::QW-1:0]);
  assign fall_idx = nqp_pkg::DIAG_W'(row_q) + nqp_pkg::DIAG_W'(nqp_pkg::MAX_QUEENS - 1)
                  - nqp_pkg::DIAG_W'(col_q[nqp_pkg::QW-1:0]);
  assign col_safe = !colm_q[col_q[nqp_pkg::QW-1:0]] && !rise_q[rise_idx] && !fall_q[fall_idx];
  assign count_nx = count_q + nqp_pkg::CNT_W'(col_safe);
  assign rem_ext  = {rem_q, rnd_q[nqp_pkg::RANDOM_WIDTH-1]};
  assign row_nx   = nqp_pkg::CNT_W'(row_q) + nqp_pkg::CNT_W'(1);

  always_comb begin
    state_d      = state_q;
    board_size_d = board_size_q;
    colm_d       = colm_q;
    rise_d       = rise_q;
    fall_d       = fall_q;
    next_row_d   = next_row_q;
    rnd_d        = rnd_q;
    row_d        = row_q;
    col_d        = col_q;
    count_d      = count_q;
    rem_d        = rem_q;
    seen_d       = seen_q;
    bit_d        = bit_q;
    chosen_d     = chosen_q;
    status_d     = status_q;
    last_d       = last_q;

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          rnd_d    = in_i.random_value;
          col_d    = '0;
          count_d  = '0;
          status_d = 1'b0;
          last_d   = 1'b0;
          chosen_d = '0;
          if (next_row_q >= n_eff) begin
            row_d      = '0;
            colm_d     = '0;
            rise_d     = '0;
            fall_d     = '0;
            next_row_d = '0;
          end else begin
            row_d = next_row_q[nqp_pkg::QW-1:0];
          end
          state_d = ST_COUNT;
        end
      end

      ST_COUNT: begin
        count_d = count_nx;
        col_d   = col_q + nqp_pkg::CNT_W'(1);
        if (col_q == n_eff - nqp_pkg::CNT_W'(1)) begin
          if (count_nx == '0) begin
            // dead end: report and start over
            status_d   = 1'b1;
            last_d     = 1'b1;
            colm_d     = '0;
            rise_d     = '0;
            fall_d     = '0;
            next_row_d = '0;
            state_d    = ST_OUT;
          end else begin
            rem_d   = '0;
            bit_d   = nqp_pkg::RBIT_W'(nqp_pkg::RANDOM_WIDTH - 1);
            state_d = ST_MOD;
          end
        end
      end

      ST_MOD: begin
        // restoring remainder, MSB first
        if (rem_ext >= {1'b0, count_q}) begin
          rem_d = nqp_pkg::CNT_W'(rem_ext - {1'b0, count_q});
        end else begin
          rem_d = nqp_pkg::CNT_W'(rem_ext);
        end
        rnd_d = rnd_q << 1;
        bit_d = bit_q - nqp_pkg::RBIT_W'(1);
        if (bit_q == '0) begin
          col_d   = '0;
          seen_d  = '0;
          state_d = ST_PICK;
        end
      end

      ST_PICK: begin
        col_d = col_q + nqp_pkg::CNT_W'(1);
        if (col_safe) begin
          seen_d = seen_q + nqp_pkg::CNT_W'(1);
          if (seen_q == rem_q) begin
            chosen_d = col_q[nqp_pkg::QW-1:0];
            state_d  = ST_OUT;
            if (row_nx >= n_eff) begin
              // board complete
              last_d     = 1'b1;
              colm_d     = '0;
              rise_d     = '0;
              fall_d     = '0;
              next_row_d = '0;
            end else begin
              colm_d[col_q[nqp_pkg::QW-1:0]] = 1'b1;
              rise_d[rise_idx]               = 1'b1;
              fall_d[fall_idx]               = 1'b1;
              next_row_d                     = row_nx;
            end
          end
        end
      end

      ST_OUT: begin
        if (out_o.ready) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Size write restarts the attempt (to be issued only while idle; the block does not enforce this)
    if (cfg_wr && reg_idx == nqp_pkg::REG_BOARD_SIZE) begin
      board_size_d = pwdata[nqp_pkg::SIZE_W-1:0];
      colm_d       = '0;
      rise_d       = '0;
      fall_d       = '0;
      next_row_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      board_size_q <= nqp_pkg::BOARD_SIZE_RST;
      colm_q       <= '0;
      rise_q       <= '0;
      fall_q       <= '0;
      next_row_q   <= '0;
    end else begin
      state_q      <= state_d;
      board_size_q <= board_size_d;
      colm_q       <= colm_d;
      rise_q       <= rise_d;
      fall_q       <= fall_d;
      next_row_q   <= next_row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rnd_q    <= rnd_d;
    row_q    <= row_d;
    col_q    <= col_d;
    count_q  <= count_d;
    rem_q    <= rem_d;
    seen_q   <= seen_d;
    bit_q    <= bit_d;
    chosen_q <= chosen_d;
    status_q <= status_d;
    last_q   <= last_d;
  end

  assign in_i.ready            = (state_q == ST_IDLE);
  assign out_o.valid           = (state_q == ST_OUT);
  assign out_o.row             = nqp_pkg::ROW_W'(row_q);
  assign out_o.column          = nqp_pkg::COLUMN_W'(chosen_q);
  assign out_o.candidate_count = nqp_pkg::COUNT_W'(count_q);
  assign out_o.status          = status_q;
  assign out_o.last            = last_q;

  // Checks
  `NQP_ASSERT(a_no_overlap, clk_i, rst_ni, !(in_i.ready && out_o.valid), "ready while result pending")
  `NQP_ASSERT(a_busy_after_accept, clk_i, rst_ni, in_i.valid && in_i.ready |=> !in_i.ready, "ready right after accept")
  `NQP_ASSERT(a_dead_end, clk_i, rst_ni, out_o.valid && out_o.status |-> out_o.last && out_o.column == '0 && out_o.candidate_count == '0, "bad dead-end result")
  `NQP_ASSERT(a_placed, clk_i, rst_ni, out_o.valid && !out_o.status |-> out_o.candidate_count != '0 && nqp_pkg::CNT_W'(out_o.column) < n_eff, "bad placement result")

endmodule

`default_nettype wire
